// ----- rtl/fdf_pkg.sv -----
// ----------------------------------------------------------------------------
// fdf_pkg
// types and constants shared by the flood duplicate filter
// ----------------------------------------------------------------------------
`default_nettype none

package fdf_pkg;

  localparam int SRC_W     = 56;
  localparam int ID_W      = 16;
  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 2;

  // header flag bit that marks chat
  localparam int CHAT_BIT = 3;

  localparam logic [BYTE_W-1:0] MIN_LEN_RESET = 8'd22;

  localparam logic [VERDICT_W-1:0] VERDICT_SHORT     = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NEW       = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_FORWARD   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_length;
    logic [SRC_W-1:0]  src_call;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] frame_flags;
    logic [BYTE_W-1:0] hop_limit;
  } in_item_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [BYTE_W-1:0]    forwarded_hop_limit;
    logic                 is_chat;
  } out_item_t;

  // one cache entry as it travels along the row of cells
  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] source;
    logic [ID_W-1:0]  message_id;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_REPORT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/fdf_cell.sv -----
// ----------------------------------------------------------------------------
// fdf_cell
// one cache entry of the ring, takes its neighbour's entry on each shift
// ----------------------------------------------------------------------------
`default_nettype none

module fdf_cell
  import fdf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire entry_t prev,
  output entry_t      entry
);

  logic             valid;
  logic [SRC_W-1:0] source;
  logic [ID_W-1:0]  message_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev.valid;
    end
  end

  // key bits only count while valid is set
  always_ff @(posedge clk) begin
    if (shift) begin
      source     <= prev.source;
      message_id <= prev.message_id;
    end
  end

  assign entry.valid      = valid;
  assign entry.source     = source;
  assign entry.message_id = message_id;

endmodule

`default_nettype wire

// ----- rtl/flood_duplicate_filter.sv -----
// ----------------------------------------------------------------------------
// flood_duplicate_filter
// duplicate suppression for flooded mesh frames with a ring cache of keys
// ----------------------------------------------------------------------------
// Each input transaction carries one received frame header. A frame shorter
// than min_frame_length gets verdict "too short" at once. Otherwise its
// (source, message id) key is checked against the last CACHE_DEPTH new keys,
// held in a ring of CACHE_DEPTH cells that rotates one place per cycle past a
// single comparator at the ring's tail, which checks each entry as it passes.
// After a full turn the ring is back in order with the oldest key in the tail
// cell; a new key is then pushed in at the head and the oldest falls out,
// which is the same as overwriting the oldest entry round-robin. A looked-up
// frame goes through accept, ring scan, update and report, where it waits
// for the output register to free up; a short frame skips scan and update.
// A new frame is accepted only in idle, after the report. The result sits in
// an output register, so a new frame is taken while an earlier result still
// waits. Valid bits of the ring are cleared by reset directly, so there is no
// clearing pass. min_frame_length is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module flood_duplicate_filter
  import fdf_pkg::*;
#(
  parameter int CACHE_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [BYTE_W-1:0] cfg_wr_data,
  // frame headers in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // verdicts out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data
);

  localparam int CNT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_DEPTH - 1);

  state_t            state;
  state_t            state_next;
  logic [BYTE_W-1:0] min_frame_length;
  in_item_t          item;
  logic              short_frame;
  logic              hit;
  logic              hit_next;
  logic [CNT_W-1:0]  scan_count;
  logic [CNT_W-1:0]  scan_count_next;

  logic   in_accept;
  logic   is_short;
  logic   shift;
  logic   insert;
  logic   load_out;
  logic   match;
  entry_t head;
  entry_t ring [CACHE_DEPTH];
  out_item_t result;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_length <= MIN_LEN_RESET;
    end else if (cfg_wr_en) begin
      min_frame_length <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // input side: one frame in work at a time
  // --------------------------------------------------------------------------
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign is_short  = (in_data.frame_length < min_frame_length);

  // header held for the whole lookup
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item        <= in_data;
      short_frame <= is_short;
    end
  end

  // --------------------------------------------------------------------------
  // ring of cache cells; tail feeds back to head while scanning,
  // the new key goes in at the head on a miss
  // --------------------------------------------------------------------------
  assign insert = (state == S_UPDATE) && !hit;
  assign shift  = (state == S_SCAN) || insert;

  always_comb begin
    if (insert) begin
      head.valid      = 1'b1;
      head.source     = item.src_call;
      head.message_id = item.message_id;
    end else begin
      head = ring[CACHE_DEPTH-1];
    end
  end

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    fdf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .prev  ((i == 0) ? head : ring[(i == 0) ? 0 : i - 1]),
      .entry (ring[i])
    );
  end

  // single comparator at the tail of the ring
  assign match = ring[CACHE_DEPTH-1].valid
              && (ring[CACHE_DEPTH-1].source == item.src_call)
              && (ring[CACHE_DEPTH-1].message_id == item.message_id);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hit        <= 1'b0;
      scan_count <= '0;
    end else begin
      state      <= state_next;
      hit        <= hit_next;
      scan_count <= scan_count_next;
    end
  end

  always_comb begin
    state_next      = state;
    hit_next        = hit;
    scan_count_next = scan_count;
    load_out        = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          hit_next        = 1'b0;
          scan_count_next = '0;
          state_next      = is_short ? S_REPORT : S_SCAN;
        end
      end
      S_SCAN: begin
        // one ring place per cycle, a full turn realigns the ring
        hit_next        = hit || match;
        scan_count_next = scan_count + CNT_W'(1);
        if (scan_count == LAST_CNT) begin
          scan_count_next = '0;
          state_next      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // verdict
  // --------------------------------------------------------------------------
  always_comb begin
    result.verdict             = VERDICT_SHORT;
    result.forwarded_hop_limit = '0;
    result.is_chat             = 1'b0;
    if (short_frame) begin
      result.verdict = VERDICT_SHORT;
    end else if (hit) begin
      result.verdict = VERDICT_DUPLICATE;
    end else begin
      result.is_chat = item.frame_flags[CHAT_BIT];
      if (item.hop_limit > BYTE_W'(1)) begin
        result.verdict             = VERDICT_FORWARD;
        result.forwarded_hop_limit = item.hop_limit - BYTE_W'(1);
      end else begin
        result.verdict = VERDICT_NEW;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !is_short) |=> (state == S_SCAN && scan_count == '0 && !hit))
    else $error("scan did not start from a clean count");

  a_short_skips_ring: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_short) |=> (state == S_REPORT))
    else $error("short frame entered the cache lookup");

  a_ring_still_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_REPORT) |-> !shift)
    else $error("cache ring moved outside a lookup");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> ($past(state) == S_SCAN && $past(scan_count) == LAST_CNT))
    else $error("ring update without a full turn");

endmodule

`default_nettype wire
